### rtl/core/probe_latency_tracker_core_defines.svh
// Assertion macros used by the probe latency tracker controller.
`ifndef PROBE_LATENCY_TRACKER_CORE_DEFINES_SVH
`define PROBE_LATENCY_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PLT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PLT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/plt_pkg.sv
// Types, constants and codes of the probe latency tracker.
package plt_pkg;
   localparam int BACKLOG_DEF = 64;
   localparam int ID_W        = 16;
   localparam int TIME_W      = 48;
   localparam int TRIP_W      = 32;
   localparam int AVG_W       = 40;
   localparam int CNT_W       = 32;
   localparam int MAXS_W      = 31;
   localparam int DELTA_W     = 17;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_W       = 44;
   localparam int DEN_W       = 33;
   localparam int DROP_W      = 2;

   localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FOREIGN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENDS = 2'd1;

   localparam logic signed [DELTA_W-1:0] DROP_OFFSET = 17'sd10;
   localparam logic [DROP_W-1:0]         DROP_LIMIT  = 2'd2;
   localparam logic [DEN_W-1:0]          DROP_DIVISOR = 33'd9;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] now_us;
      logic [ID_W-1:0]   reply_id;
   } plt_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    query_id;
      logic [DELTA_W-1:0] seq_delta;
      logic [TRIP_W-1:0]  trip_us;
      logic [AVG_W-1:0]   avg_trip;
      logic [TRIP_W-1:0]  max_trip;
      logic [TRIP_W-1:0]  min_trip;
      logic [CNT_W-1:0]   recv_count;
      logic [CNT_W-1:0]   missed_count;
      logic [CNT_W-1:0]   lagged_count;
      logic [CNT_W-1:0]   sent_count;
      logic               limit_reached;
   } plt_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_SEND, ST_CMP, ST_TRIP, ST_PICK,
      ST_DDIV, ST_LAG, ST_ADIV, ST_FIN, ST_OUT
   } plt_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_CLEAR, OP_SEND, OP_NEXT, OP_FOREIGN, OP_TRIP,
      OP_AVG_INIT, OP_DROP_START, OP_DROP_END, OP_LAG, OP_AVG_START,
      OP_AVG_END, OP_RECV, OP_LOAD
   } plt_op_type;

   typedef struct packed {
      plt_op_type op;
   } plt_cmd_type;

   typedef struct packed {
      logic action;
      logic hit;
      logic last;
      logic avg_zero;
      logic drop_go;
      logic lag_go;
      logic c_nonzero;
      logic div_done;
   } plt_stat_type;
endpackage

### rtl/core/plt_div.sv
// Restoring serial divider, one quotient bit per cycle.
module plt_div
   import plt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_DW = $clog2(NUM_W + 1);

   logic [CNT_DW-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    part, diff;
   logic              ge;

   always_comb begin
      part    = {rem_ff, quo_ff[NUM_W-1]};
      diff    = part - {1'b0, den_ff};
      ge      = part >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in = CNT_DW'(NUM_W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_DW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

### rtl/core/plt_dpath.sv
// Datapath: probe table, statistics registers, divider and result register.
module plt_dpath
   import plt_pkg::*;
#(
   parameter int BACKLOG = BACKLOG_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  plt_cmd_type           cmd,
   output plt_stat_type          stat,
   input  plt_req_type           req_data,
   output plt_rsp_type           rsp_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int IDX_W = (BACKLOG > 1) ? $clog2(BACKLOG) : 1;
   localparam int ENT_W = ID_W + TIME_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BACKLOG - 1);

   logic [ENT_W-1:0] tbl_mem [BACKLOG];
   logic [1:0]       flag_mem [BACKLOG];
   logic [ENT_W-1:0] tbl_rd_ff;
   logic [1:0]       flag_rd_ff;
   logic             tbl_we, flag_we;
   logic [ENT_W-1:0] tbl_wd;
   logic [1:0]       flag_wd;

   logic [ID_W-1:0]    start_ff, start_in;
   logic [MAXS_W-1:0]  maxs_ff, maxs_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [IDX_W-1:0]   idx_ff, idx_in, wpos_ff, wpos_in;
   logic [CNT_W-1:0]   sent_ff, sent_in, recv_ff, recv_in;
   logic [CNT_W-1:0]   missed_ff, missed_in, lagged_ff, lagged_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [TRIP_W-1:0]  max_ff, max_in, min_ff, min_in, trip_ff, trip_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [DEN_W-1:0]   c_ff, c_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ID_W-1:0]    qid_ff, qid_in;
   plt_rsp_type        rsp_ff, rsp_in;
   logic               act_ff, act_in;

   logic [ID_W-1:0]   send_id;
   logic [TIME_W-1:0] span;
   logic [TRIP_W-1:0] trip_new;
   logic [AVG_W-1:0]  t256;
   logic [NUM_W-1:0]  a10, m256, div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_start, div_done, avg_ge;
   logic [NUM_W-1:0]  div_quo;

   plt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      send_id  = start_ff + sent_ff[ID_W-1:0];
      span     = now_ff - tbl_rd_ff[TIME_W-1:0];
      trip_new = (span[TIME_W-1:TRIP_W] != '0) ? '1 : span[TRIP_W-1:0];
      t256     = {trip_ff, 8'b0};
      avg_ge   = t256 >= avg_ff;
      a10      = {1'b0, avg_ff, 3'b0} + {3'b0, avg_ff, 1'b0};
      m256     = {4'b0, max_ff, 8'b0};
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DROP_DIVISOR;
      if (cmd.op == OP_DROP_START) begin
         div_start = 1'b1;
         div_num   = (a10 > m256) ? a10 - m256 : '0;
      end else if (cmd.op == OP_AVG_START) begin
         div_start = 1'b1;
         div_den   = c_ff;
         div_num   = avg_ge ? {4'b0, t256 - avg_ff}
                            : {4'b0, avg_ff - t256} + {11'b0, c_ff} - 1'b1;
      end
   end

   always_comb begin
      start_in  = start_ff;
      maxs_in   = maxs_ff;
      now_in    = now_ff;
      rid_in    = rid_ff;
      act_in    = act_ff;
      idx_in    = idx_ff;
      wpos_in   = wpos_ff;
      sent_in   = sent_ff;
      recv_in   = recv_ff;
      missed_in = missed_ff;
      lagged_in = lagged_ff;
      avg_in    = avg_ff;
      max_in    = max_ff;
      min_in    = min_ff;
      drop_in   = drop_ff;
      c_in      = c_ff;
      trip_in   = trip_ff;
      delta_in  = delta_ff;
      kind_in   = kind_ff;
      qid_in    = qid_ff;
      rsp_in    = rsp_ff;
      tbl_we    = 1'b0;
      tbl_wd    = {send_id, now_ff};
      flag_we   = 1'b0;
      flag_wd   = 2'b11;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_ID:  start_in = csr_data[ID_W-1:0];
            CSR_MAX_SENDS: maxs_in  = csr_data[MAXS_W-1:0];
            default: ;
         endcase
      end
      case (cmd.op)
         OP_CAPTURE: begin
            now_in = req_data.now_us;
            rid_in = req_data.reply_id;
            act_in = req_data.action;
            idx_in = req_data.action ? '0 : wpos_ff;
         end
         OP_CLEAR: begin
            flag_we = 1'b1;
            flag_wd = 2'b01;
            idx_in  = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         end
         OP_SEND: begin
            if (!flag_rd_ff[0] && missed_ff != '1) missed_in = missed_ff + 1'b1;
            tbl_we   = 1'b1;
            flag_we  = 1'b1;
            flag_wd  = 2'b10;
            if (sent_ff != '1) sent_in = sent_ff + 1'b1;
            wpos_in  = (wpos_ff == IDX_LAST) ? '0 : wpos_ff + 1'b1;
            kind_in  = KIND_SENT;
            qid_in   = send_id;
            delta_in = '0;
            trip_in  = '0;
         end
         OP_NEXT: idx_in = idx_ff + 1'b1;
         OP_FOREIGN: begin
            kind_in  = KIND_FOREIGN;
            qid_in   = rid_ff;
            delta_in = '0;
            trip_in  = '0;
         end
         OP_TRIP: begin
            flag_we  = 1'b1;
            flag_wd  = 2'b11;
            trip_in  = trip_new;
            if (trip_new > max_ff) max_in = trip_new;
            if (recv_ff == '0 || trip_new < min_ff) min_in = trip_new;
            c_in     = {1'b0, recv_ff} + 1'b1;
            kind_in  = KIND_MATCH;
            qid_in   = rid_ff;
            delta_in = {1'b0, rid_ff} - {1'b0, start_ff};
         end
         OP_AVG_INIT: avg_in = t256;
         OP_DROP_END: begin
            avg_in  = (div_quo[NUM_W-1:AVG_W] != '0) ? '1 : div_quo[AVG_W-1:0];
            if (c_ff != '0) c_in = c_ff - 1'b1;
            drop_in = drop_ff + 1'b1;
         end
         OP_LAG: begin
            if (c_ff != '0) c_in = c_ff - 1'b1;
            if (lagged_ff != '1) lagged_in = lagged_ff + 1'b1;
         end
         OP_AVG_END: begin
            avg_in = avg_ge ? avg_ff + div_quo[AVG_W-1:0] : avg_ff - div_quo[AVG_W-1:0];
         end
         OP_RECV: recv_in = c_ff[DEN_W-1] ? '1 : c_ff[CNT_W-1:0];
         OP_LOAD: begin
            rsp_in.kind          = kind_ff;
            rsp_in.query_id      = qid_ff;
            rsp_in.seq_delta     = delta_ff;
            rsp_in.trip_us       = trip_ff;
            rsp_in.avg_trip      = avg_ff;
            rsp_in.max_trip      = max_ff;
            rsp_in.min_trip      = min_ff;
            rsp_in.recv_count    = recv_ff;
            rsp_in.missed_count  = missed_ff;
            rsp_in.lagged_count  = lagged_ff;
            rsp_in.sent_count    = sent_ff;
            rsp_in.limit_reached = (maxs_ff != '0) && (sent_ff > {1'b0, maxs_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         maxs_ff   <= '0;
         idx_ff    <= '0;
         wpos_ff   <= '0;
         sent_ff   <= '0;
         recv_ff   <= '0;
         missed_ff <= '0;
         lagged_ff <= '0;
         avg_ff    <= '0;
         max_ff    <= '0;
         min_ff    <= '0;
         drop_ff   <= '0;
      end else begin
         start_ff  <= start_in;
         maxs_ff   <= maxs_in;
         idx_ff    <= idx_in;
         wpos_ff   <= wpos_in;
         sent_ff   <= sent_in;
         recv_ff   <= recv_in;
         missed_ff <= missed_in;
         lagged_ff <= lagged_in;
         avg_ff    <= avg_in;
         max_ff    <= max_in;
         min_ff    <= min_in;
         drop_ff   <= drop_in;
      end
      now_ff   <= now_in;
      rid_ff   <= rid_in;
      act_ff   <= act_in;
      c_ff     <= c_in;
      trip_ff  <= trip_in;
      delta_ff <= delta_in;
      kind_ff  <= kind_in;
      qid_ff   <= qid_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[idx_ff] <= tbl_wd;
      tbl_rd_ff <= tbl_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[idx_ff] <= flag_wd;
      flag_rd_ff <= flag_mem[idx_ff];
   end

   always_comb begin
      stat.action    = act_ff;
      stat.hit       = flag_rd_ff[1] && (tbl_rd_ff[ENT_W-1:TIME_W] == rid_ff);
      stat.last      = idx_ff == IDX_LAST;
      stat.avg_zero  = avg_ff == '0;
      stat.drop_go   = ($signed(delta_ff) == DROP_OFFSET) && (drop_ff != DROP_LIMIT);
      stat.lag_go    = ($signed(delta_ff) > DROP_OFFSET) && ({1'b0, t256} > {avg_ff, 1'b0});
      stat.c_nonzero = c_ff != '0;
      stat.div_done  = div_done;
   end

   assign rsp_data = rsp_ff;
endmodule

### rtl/core/plt_ctrl.sv
// Controller state machine: sequences table scan, updates and result beats.
`include "probe_latency_tracker_core_defines.svh"
module plt_ctrl
   import plt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  plt_stat_type stat,
   output plt_cmd_type  cmd
);
   plt_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (stat.last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = stat.action ? ST_CMP : ST_SEND;
         ST_SEND:  state_in = ST_OUT;
         ST_CMP: begin
            if (stat.hit) state_in = ST_TRIP;
            else if (stat.last) state_in = ST_OUT;
            else state_in = ST_READ;
         end
         ST_TRIP:  state_in = ST_PICK;
         ST_PICK: begin
            if (stat.avg_zero) state_in = ST_FIN;
            else if (stat.drop_go) state_in = ST_DDIV;
            else state_in = ST_LAG;
         end
         ST_DDIV:  if (stat.div_done) state_in = ST_LAG;
         ST_LAG: begin
            if (stat.lag_go || !stat.c_nonzero) state_in = ST_FIN;
            else state_in = ST_ADIV;
         end
         ST_ADIV:  if (stat.div_done) state_in = ST_FIN;
         ST_FIN:   state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         ST_CLEAR: cmd.op = OP_CLEAR;
         ST_IDLE:  if (req_valid) cmd.op = OP_CAPTURE;
         ST_SEND:  cmd.op = OP_SEND;
         ST_CMP: begin
            if (stat.hit) cmd.op = OP_NONE;
            else if (stat.last) cmd.op = OP_FOREIGN;
            else cmd.op = OP_NEXT;
         end
         ST_TRIP:  cmd.op = OP_TRIP;
         ST_PICK: begin
            if (stat.avg_zero) cmd.op = OP_AVG_INIT;
            else if (stat.drop_go) cmd.op = OP_DROP_START;
         end
         ST_DDIV:  if (stat.div_done) cmd.op = OP_DROP_END;
         ST_LAG: begin
            if (stat.lag_go) cmd.op = OP_LAG;
            else if (stat.c_nonzero) cmd.op = OP_AVG_START;
         end
         ST_ADIV:  if (stat.div_done) cmd.op = OP_AVG_END;
         ST_FIN:   cmd.op = OP_RECV;
         ST_OUT:   if (rsp_free) cmd.op = OP_LOAD;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_LOAD) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PLT_ASSERT_NXT(a_load_beat, clock, reset, state_ff == ST_OUT && rsp_free, rsp_valid_ff, "result beat not raised after load")
   `PLT_ASSERT_NXT(a_accept_scan, clock, reset, req_valid && req_ready, state_ff == ST_READ, "accepted beat did not start table read")
   `PLT_ASSERT_NXT(a_hit_trip, clock, reset, state_ff == ST_CMP && stat.hit, state_ff == ST_TRIP, "table hit did not go to trip update")
endmodule

### rtl/core/probe_latency_tracker_core.sv
// Top level of the probe latency tracker.
//  Channel  Dir  Handshake             Beat
//  req_     in   req_valid/req_ready   plt_req_type: action, now_us, reply_id
//  rsp_     out  rsp_valid/rsp_ready   plt_rsp_type: one result per request
//  csr_     in   csr_valid/csr_ready   csr_index, csr_data (always ready)
// Send: read, send and output states run from accept to load; a new request is taken only
// after the result is loaded. Response: a read and a compare per table entry scanned up to
// the first hit (every entry for no match), plus up to two passes of the serial divider.
// After reset a clearing pass over all BACKLOG entry flags runs before req_ready rises.
// A stalled result beat holds in the output register; the next request is taken and
// worked until its own result needs that register.
module probe_latency_tracker_core
   import plt_pkg::*;
#(
   parameter int BACKLOG = BACKLOG_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plt_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plt_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   plt_cmd_type  cmd;
   plt_stat_type stat;

   assign csr_ready = 1'b1;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   plt_dpath #(.BACKLOG(BACKLOG)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );
endmodule
